>>> hw/rtl/drts_pkg.sv
package drts_pkg;

    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDataW = 32;

    localparam logic [1:0] CFG_MIN_CONF = 2'd0;
    localparam logic [1:0] CFG_LATE_TOL = 2'd1;
    localparam logic [1:0] CFG_AUDIO_AGE = 2'd2;
    localparam logic [1:0] CFG_IDLE_PERIOD = 2'd3;

    localparam logic [1:0] MODE_AUDIO = 2'd0;
    localparam logic [1:0] MODE_TARGET = 2'd1;
    localparam logic [1:0] MODE_TICK = 2'd2;
    localparam logic [1:0] MODE_RENDER = 2'd3;

    localparam logic [1:0] TRIG_NONE = 2'd0;
    localparam logic [1:0] TRIG_BEAT = 2'd1;
    localparam logic [1:0] TRIG_AUDIO = 2'd2;
    localparam logic [1:0] TRIG_IDLE = 2'd3;

    localparam int unsigned QueueDepthDef = 2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] time_us;
        logic [63:0] event_time_us;
        logic [63:0] source_time_us;
        logic [31:0] render_cost;
        logic [31:0] output_cost;
        logic [31:0] epoch;
        logic [31:0] beat;
        logic [15:0] certainty;
        logic        certainty_finite;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  trigger;
        logic [63:0] out_source_us;
        logic [63:0] out_event_us;
        logic [31:0] out_beat;
        logic [15:0] out_certainty;
        logic        accepted;
        logic [31:0] rejected_count;
        logic [31:0] missed_count;
        logic [31:0] reserve_count;
        logic [31:0] stale_audio_count;
        logic [31:0] idle_miss_count;
    } t_out_item;

    // Classified command from front to back
    typedef struct packed {
        t_in_item item;
        logic     invalid;
    } t_cmd;

endpackage

>>> hw/rtl/drts_front.sv
module drts_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  drts_pkg::t_in_item i_item,
    input  logic [15:0]        i_min_conf,
    output logic               o_valid,
    input  logic               i_ready,
    output drts_pkg::t_cmd     o_cmd
);
    import drts_pkg::*;

    t_cmd r_cmd, n_cmd;
    logic r_valid, n_valid;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_cmd = r_cmd;

    // Register item and mark invalid targets
    always_comb begin
        n_valid = r_valid;
        n_cmd = r_cmd;
        if (o_ready) begin
            n_valid = i_valid;
            n_cmd.item = i_item;
            n_cmd.invalid = !i_item.certainty_finite || (i_item.certainty < i_min_conf)
                || (i_item.event_time_us == 64'd0) || (i_item.output_cost == 32'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end
endmodule

>>> hw/rtl/drts_queue.sv
module drts_queue #(
    parameter int unsigned Depth = drts_pkg::QueueDepthDef
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  drts_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output drts_pkg::t_cmd o_cmd
);
    import drts_pkg::*;

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

    t_cmd r_mem [Depth];
    logic [PtrW-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [PtrW:0] r_cnt, n_cnt;
    logic push, pop;

    assign o_ready = (r_cnt != Depth[PtrW:0]);
    assign o_valid = (r_cnt != '0);
    assign o_cmd = r_mem[r_rd];
    assign push = i_valid && o_ready;
    assign pop = o_valid && i_ready;

    // Advance pointers with wrap
    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        if (push) n_wr = (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + 1'b1;
        if (pop) n_rd = (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + 1'b1;
        n_cnt = r_cnt + {{PtrW{1'b0}}, push} - {{PtrW{1'b0}}, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
            r_cnt <= n_cnt;
        end
        if (push) r_mem[r_wr] <= i_cmd;
    end
endmodule

>>> hw/rtl/drts_div.sv
module drts_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quot
);
    // One quotient bit per cycle, restoring
    logic        r_busy, n_busy;
    logic [6:0]  r_cnt, n_cnt;
    logic [63:0] r_q, n_q;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den, n_den;
    logic [32:0] shifted;
    logic        r_done, n_done;

    assign o_done = r_done;
    assign o_quot = r_q;
    assign shifted = {r_rem[31:0], r_q[63]};

    always_comb begin
        n_busy = r_busy;
        n_cnt = r_cnt;
        n_q = r_q;
        n_rem = r_rem;
        n_den = r_den;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt = 7'd64;
            n_q = i_num;
            n_rem = '0;
            n_den = i_den;
        end else if (r_busy) begin
            if (shifted >= {1'b0, r_den}) begin
                n_rem = shifted - {1'b0, r_den};
                n_q = {r_q[62:0], 1'b1};
            end else begin
                n_rem = shifted;
                n_q = {r_q[62:0], 1'b0};
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_q <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
    end
endmodule

>>> hw/rtl/drts_back.sv
module drts_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  drts_pkg::t_cmd      i_cmd,
    input  logic [31:0]         i_late_tol,
    input  logic [31:0]         i_audio_age,
    input  logic [31:0]         i_idle_period,
    output logic                o_valid,
    input  logic                i_ready,
    output drts_pkg::t_out_item o_item
);
    import drts_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_TICK = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic        r_aud_w, n_aud_w;
    logic [63:0] r_aud_t, n_aud_t;
    logic        r_tgt_w, n_tgt_w;
    logic [63:0] r_h_ev, n_h_ev, r_h_src, n_h_src;
    logic [31:0] r_h_rc, n_h_rc, r_h_oc, n_h_oc, r_h_ep, n_h_ep, r_h_bt, n_h_bt;
    logic [15:0] r_h_cert, n_h_cert;
    logic        r_f_v, n_f_v;
    logic [31:0] r_f_ep, n_f_ep, r_f_bt, n_f_bt;
    logic [63:0] r_next_idle, n_next_idle;
    logic [31:0] r_c_rej, n_c_rej, r_c_miss, n_c_miss, r_c_res, n_c_res;
    logic [31:0] r_c_stale, n_c_stale, r_c_idle, n_c_idle;
    logic [63:0] r_now, n_now;
    logic [63:0] r_start, n_start;
    t_out_item   r_out, n_out;
    logic        r_out_v, n_out_v;

    logic        div_start, div_done;
    logic [63:0] div_q;
    logic [64:0] lead;
    logic [31:0] room;
    t_in_item    it;

    assign it = i_cmd.item;
    assign lead = {33'd0, r_h_rc} + {33'd0, r_h_oc};
    assign room = ~r_c_idle;
    assign o_ready = (r_state == ST_IDLE) && !r_out_v;
    assign o_valid = r_out_v;
    assign o_item = r_out;

    drts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_now - r_next_idle),
        .i_den   ((i_idle_period == 32'd0) ? 32'd1 : i_idle_period),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // Sequence each command and build its result
    always_comb begin
        n_state = r_state;
        n_aud_w = r_aud_w; n_aud_t = r_aud_t; n_tgt_w = r_tgt_w;
        n_h_ev = r_h_ev; n_h_src = r_h_src; n_h_rc = r_h_rc; n_h_oc = r_h_oc;
        n_h_ep = r_h_ep; n_h_bt = r_h_bt; n_h_cert = r_h_cert;
        n_f_v = r_f_v; n_f_ep = r_f_ep; n_f_bt = r_f_bt;
        n_next_idle = r_next_idle;
        n_c_rej = r_c_rej; n_c_miss = r_c_miss; n_c_res = r_c_res;
        n_c_stale = r_c_stale; n_c_idle = r_c_idle;
        n_now = r_now; n_start = r_start;
        n_out = r_out; n_out_v = r_out_v;
        div_start = 1'b0;
        if (r_out_v && i_ready) n_out_v = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid && o_ready) begin
                    n_out = '0;
                    case (it.mode)
                        MODE_AUDIO: begin
                            n_aud_t = it.time_us;
                            n_aud_w = 1'b1;
                        end
                        MODE_TARGET: begin
                            n_state = ST_OUT;
                            if (i_cmd.invalid) begin
                                if (r_c_rej != '1) n_c_rej = r_c_rej + 1'b1;
                            end else if (!(r_f_v && it.epoch == r_f_ep && it.beat <= r_f_bt)
                                && !(r_tgt_w && it.epoch == r_h_ep && it.beat < r_h_bt)) begin
                                n_h_ev = it.event_time_us; n_h_src = it.source_time_us;
                                n_h_rc = it.render_cost; n_h_oc = it.output_cost;
                                n_h_ep = it.epoch; n_h_bt = it.beat;
                                n_h_cert = it.certainty; n_tgt_w = 1'b1;
                                n_out.accepted = 1'b1;
                            end
                        end
                        MODE_TICK: begin
                            n_now = it.time_us;
                            n_start = ({1'b0, r_h_ev} > lead) ? 64'({1'b0, r_h_ev} - lead)
                                                               : 64'd0;
                            n_state = ST_TICK;
                        end
                        MODE_RENDER: begin
                            n_next_idle = it.time_us + {32'd0, i_idle_period};
                        end
                        default: ;
                    endcase
                end
            end
            ST_TICK: begin
                n_state = ST_OUT;
                if (r_tgt_w && r_now >= r_start
                    && (r_now - r_start) <= {32'd0, i_late_tol} && r_now <= r_h_ev) begin
                    n_tgt_w = 1'b0; n_f_v = 1'b1; n_f_ep = r_h_ep; n_f_bt = r_h_bt;
                    n_out.trigger = TRIG_BEAT; n_out.out_source_us = r_h_src;
                    n_out.out_event_us = r_h_ev; n_out.out_beat = r_h_bt;
                    n_out.out_certainty = r_h_cert;
                end else if (r_tgt_w && r_now < r_start
                    && lead >= {1'b0, r_start - r_now}) begin
                    if (r_c_res != '1) n_c_res = r_c_res + 1'b1;
                end else begin
                    if (r_tgt_w && r_now >= r_start) begin
                        n_tgt_w = 1'b0;
                        if (r_c_miss != '1) n_c_miss = r_c_miss + 1'b1;
                    end
                    if (r_aud_w && r_now >= r_aud_t
                        && (r_now - r_aud_t) <= {32'd0, i_audio_age}) begin
                        n_aud_w = 1'b0;
                        n_out.trigger = TRIG_AUDIO; n_out.out_source_us = r_aud_t;
                    end else begin
                        if (r_aud_w) begin
                            n_aud_w = 1'b0;
                            if (r_c_stale != '1) n_c_stale = r_c_stale + 1'b1;
                        end
                        if (r_next_idle == 64'd0) begin
                            n_out.trigger = TRIG_IDLE; n_out.out_source_us = r_now;
                        end else if (r_now >= r_next_idle) begin
                            n_out.trigger = TRIG_IDLE; n_out.out_source_us = r_now;
                            div_start = 1'b1;
                            n_state = ST_DIV;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_c_idle = r_c_idle + ((div_q < {32'd0, room}) ? div_q[31:0] : room);
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_v) begin
                    n_out.rejected_count = r_c_rej; n_out.missed_count = r_c_miss;
                    n_out.reserve_count = r_c_res; n_out.stale_audio_count = r_c_stale;
                    n_out.idle_miss_count = r_c_idle;
                    n_out_v = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_aud_w <= 1'b0; r_aud_t <= '0; r_tgt_w <= 1'b0;
            r_h_ev <= '0; r_h_src <= '0; r_h_rc <= '0; r_h_oc <= '0;
            r_h_ep <= '0; r_h_bt <= '0; r_h_cert <= '0;
            r_f_v <= 1'b0; r_f_ep <= '0; r_f_bt <= '0;
            r_next_idle <= '0;
            r_c_rej <= '0; r_c_miss <= '0; r_c_res <= '0;
            r_c_stale <= '0; r_c_idle <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_aud_w <= n_aud_w; r_aud_t <= n_aud_t; r_tgt_w <= n_tgt_w;
            r_h_ev <= n_h_ev; r_h_src <= n_h_src; r_h_rc <= n_h_rc; r_h_oc <= n_h_oc;
            r_h_ep <= n_h_ep; r_h_bt <= n_h_bt; r_h_cert <= n_h_cert;
            r_f_v <= n_f_v; r_f_ep <= n_f_ep; r_f_bt <= n_f_bt;
            r_next_idle <= n_next_idle;
            r_c_rej <= n_c_rej; r_c_miss <= n_c_miss; r_c_res <= n_c_res;
            r_c_stale <= n_c_stale; r_c_idle <= n_c_idle;
            r_out_v <= n_out_v;
        end
        r_now <= n_now;
        r_start <= n_start;
        r_out <= n_out;
    end
endmodule

>>> hw/rtl/deadline_render_trigger_scheduler.sv
// A target passes through ST_OUT to its result; a tick through ST_TICK and ST_OUT,
// and through ST_DIV too when idle periods were skipped (64-step serial divider).
// Throughput: one item per cycle for audio and render notes while no result waits
// on the output; a target or tick holds intake until its result has been taken.
// Reset (synchronous, active low): back end to ST_IDLE, counters and held state zero, registers at defaults.
module deadline_render_trigger_scheduler #(
    parameter int unsigned QueueDepth = drts_pkg::QueueDepthDef
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  drts_pkg::t_in_item            i_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output drts_pkg::t_out_item           o_data,
    input  logic                          i_cfg_we,
    input  logic [drts_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [drts_pkg::CfgDataW-1:0] i_cfg_data
);
    import drts_pkg::*;

    logic [15:0] r_min_conf;
    logic [31:0] r_late_tol, r_audio_age, r_idle_period;
    logic f_valid, f_ready, b_valid, b_ready;
    t_cmd f_cmd, b_cmd;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_conf <= 16'd32768;
            r_late_tol <= 32'd2000;
            r_audio_age <= 32'd5000;
            r_idle_period <= 32'd16667;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_CONF: r_min_conf <= i_cfg_data[15:0];
                CFG_LATE_TOL: r_late_tol <= i_cfg_data;
                CFG_AUDIO_AGE: r_audio_age <= i_cfg_data;
                CFG_IDLE_PERIOD: r_idle_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    drts_front u_front (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_valid (i_valid), .o_ready (o_ready), .i_item (i_data),
        .i_min_conf (r_min_conf),
        .o_valid (f_valid), .i_ready (f_ready), .o_cmd (f_cmd)
    );

    drts_queue #(.Depth(QueueDepth)) u_queue (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_valid (f_valid), .o_ready (f_ready), .i_cmd (f_cmd),
        .o_valid (b_valid), .i_ready (b_ready), .o_cmd (b_cmd)
    );

    drts_back u_back (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_valid (b_valid), .o_ready (b_ready), .i_cmd (b_cmd),
        .i_late_tol (r_late_tol), .i_audio_age (r_audio_age),
        .i_idle_period (r_idle_period),
        .o_valid (o_valid), .i_ready (i_ready), .o_item (o_data)
    );
endmodule
